// ----- rtl/core/msbr_pkg.sv -----
// Shared types and constants for the MSB-first bitstream reader.
// Field widths of the stream payloads and the operation codes.
// No dependencies.
package msbr_pkg;

	localparam int OP_W      = 3;
	localparam int ADDR_W    = 12;
	localparam int BYTE_W    = 8;
	localparam int COUNT_W   = 13;
	localparam int LEN_W     = 13;
	localparam int VALUE_W   = 32;
	localparam int IN_DATA_W = 40;   // 37 bits of fields, padded to whole bytes

	// bit offsets of the input fields inside s_tdata
	localparam int OP_LSB    = 0;
	localparam int ADDR_LSB  = OP_LSB + OP_W;
	localparam int BYTE_LSB  = ADDR_LSB + ADDR_W;
	localparam int COUNT_LSB = BYTE_LSB + BYTE_W;
	localparam int SGN_LSB   = COUNT_LSB + COUNT_W;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE      = 3'd0,
		OP_RESTART    = 3'd1,
		OP_READ_BYTES = 3'd2,
		OP_SKIP       = 3'd3,
		OP_READ_BITS  = 3'd4,
		OP_ALIGN      = 3'd5
	} op_t;

endpackage

// ----- rtl/core/msbr_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the byte store of the bitstream reader. No dependencies.
module msbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- rtl/core/msb_first_bitstream_reader.sv -----
// MSB-first bitstream reader: top level with sequencer, state registers and byte store.
// Depends on msbr_pkg and msbr_ram.
//
// Each transfer on the slave stream is one operation (write byte, restart, read
// 0-4 bytes little-endian, skip bytes, read 0-32 bits MSB-first, align) and gives
// exactly one result transfer on the master stream: the value read and the sticky
// overrun flag. The bytes live in a synchronous RAM with one read port, so every
// byte fetched costs one RAM read. An operation passes from its transfer through
// the execute state to the done state and its result. A byte read fetches its
// bytes in turn in the byte wait state; a bit read of a nonzero count alternates
// between a step state, which takes bits from the held byte or starts a fetch,
// and a wait state for each byte it fetches. A new operation is taken as soon as
// the previous result sits in the output register, even while that result waits
// for m_tready.
// The byte store has no reset: only bytes that were written may be read.
module msb_first_bitstream_reader
	import msbr_pkg::*;
#(
	parameter int BUF_DEPTH = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration: data_length
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [LEN_W-1:0]       cfg_data,
	// operation stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// operation[2:0], address[14:3], data_byte[22:15], count[35:23], is_signed[36]
	input  logic [IN_DATA_W-1:0]   s_tdata,
	// result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// value[31:0]
	output logic [VALUE_W-1:0]     m_tdata,
	// error[0]
	output logic                   m_tuser
);

	localparam int AW = $clog2(BUF_DEPTH);
	localparam int CW = $clog2(BUF_DEPTH + 1);
	localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;
	localparam logic [XW-1:0] DEPTH_X = XW'(BUF_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_BYTES_WAIT,
		S_BITS_STEP,
		S_BITS_WAIT,
		S_DONE
	} state_t;

	state_t              state_q;
	op_t                 op_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [BYTE_W-1:0]   wbyte_q;
	logic [COUNT_W-1:0]  cnt_q;
	logic                sgn_q;

	logic [LEN_W-1:0]    data_length_q;
	logic [CW-1:0]       cursor_q;
	logic [3:0]          bitpos_q;
	logic [7:0]          held_q;
	logic                flag_q;

	logic [VALUE_W-1:0]  acc_q;
	logic [5:0]          rem_q;
	logic [5:0]          nbits_q;
	logic [1:0]          idx_q;
	logic [VALUE_W-1:0]  res_q;
	logic                m_valid_q;
	logic [VALUE_W-1:0]  m_data_q;
	logic                m_err_q;

	logic [XW-1:0]       len_x;
	logic [XW-1:0]       left_x;
	logic [2:0]          nbytes;
	logic [5:0]          nbits;
	logic                ram_we;
	logic [AW-1:0]       ram_raddr;
	logic [7:0]          ram_rdata;

	// bit-take datapath, fed from the held byte or straight from the RAM
	logic [7:0]          src_byte;
	logic [2:0]          src_pos;
	logic [3:0]          avail;
	logic [3:0]          take;
	logic [7:0]          shl;
	logic [7:0]          piece;
	logic [5:0]          rem_after;
	logic [VALUE_W-1:0]  acc_bits;
	logic [VALUE_W-1:0]  acc_byte;

	function automatic logic [VALUE_W-1:0] sext(input logic [VALUE_W-1:0] v,
			input logic [5:0] n);
		logic [VALUE_W-1:0] r;
		r = v;
		if (n != 6'd0 && n < 6'd32 && v[5'(n - 6'd1)]) begin
			r = v | ({VALUE_W{1'b1}} << n);
		end
		return r;
	endfunction

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign m_tuser   = m_err_q;

	assign len_x  = (XW'(data_length_q) > DEPTH_X) ? DEPTH_X : XW'(data_length_q);
	assign left_x = (len_x > XW'(cursor_q)) ? len_x - XW'(cursor_q) : '0;
	assign nbytes = (cnt_q > COUNT_W'(4)) ? 3'd4 : cnt_q[2:0];
	assign nbits  = (cnt_q > COUNT_W'(32)) ? 6'd32 : cnt_q[5:0];

	assign ram_we = (state_q == S_EXEC) && (op_q == OP_WRITE) && (XW'(addr_q) < DEPTH_X);

	always_comb begin
		case (state_q)
			S_BYTES_WAIT: ram_raddr = AW'(cursor_q + CW'(1));
			default:      ram_raddr = AW'(cursor_q);
		endcase
	end

	assign src_byte  = (state_q == S_BITS_WAIT) ? ram_rdata : held_q;
	assign src_pos   = (state_q == S_BITS_WAIT) ? 3'd0 : bitpos_q[2:0];
	assign avail     = 4'd8 - {1'b0, src_pos};
	assign take      = (6'(avail) > rem_q) ? rem_q[3:0] : avail;
	assign shl       = src_byte << src_pos;
	assign piece     = shl >> (4'd8 - take);
	assign rem_after = rem_q - 6'(take);
	assign acc_bits  = acc_q | (VALUE_W'(piece) << rem_after);
	assign acc_byte  = acc_q | (VALUE_W'(ram_rdata) << {idx_q, 3'b000});

	msbr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (BUF_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (AW'(addr_q)),
		.wr_data (wbyte_q),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			op_q          <= OP_WRITE;
			addr_q        <= '0;
			wbyte_q       <= '0;
			cnt_q         <= '0;
			sgn_q         <= 1'b0;
			data_length_q <= '0;
			cursor_q      <= '0;
			bitpos_q      <= 4'd8;
			held_q        <= '0;
			flag_q        <= 1'b0;
			acc_q         <= '0;
			rem_q         <= '0;
			nbits_q       <= '0;
			idx_q         <= '0;
			res_q         <= '0;
			m_valid_q     <= 1'b0;
			m_data_q      <= '0;
			m_err_q       <= 1'b0;
		end else begin
			if (cfg_valid) begin
				data_length_q <= cfg_data;
			end
			// load a finished result, or drop the one just taken
			if (state_q == S_DONE && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q    <= op_t'(s_tdata[OP_LSB +: OP_W]);
						addr_q  <= s_tdata[ADDR_LSB +: ADDR_W];
						wbyte_q <= s_tdata[BYTE_LSB +: BYTE_W];
						cnt_q   <= s_tdata[COUNT_LSB +: COUNT_W];
						sgn_q   <= s_tdata[SGN_LSB];
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_q   <= '0;
					acc_q   <= '0;
					idx_q   <= '0;
					case (op_q)
						OP_RESTART: begin
							cursor_q <= '0;
							flag_q   <= 1'b0;
							held_q   <= '0;
							bitpos_q <= 4'd8;
							state_q  <= S_DONE;
						end
						OP_READ_BYTES: begin
							if (XW'(nbytes) > left_x) begin
								flag_q  <= 1'b1;
								state_q <= S_DONE;
							end else if (nbytes != 3'd0) begin
								state_q <= S_BYTES_WAIT;
							end else begin
								state_q <= S_DONE;
							end
						end
						OP_SKIP: begin
							if (XW'(cnt_q) > left_x) begin
								flag_q <= 1'b1;
							end else begin
								cursor_q <= cursor_q + CW'(cnt_q);
							end
							state_q <= S_DONE;
						end
						OP_READ_BITS: begin
							rem_q   <= nbits;
							nbits_q <= nbits;
							if (nbits != 6'd0) begin
								state_q <= S_BITS_STEP;
							end else begin
								state_q <= S_DONE;
							end
						end
						OP_ALIGN: begin
							bitpos_q <= 4'd8;
							held_q   <= '0;
							state_q  <= S_DONE;
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_BYTES_WAIT: begin
					// one byte lands per cycle; the next read is already addressed
					acc_q    <= acc_byte;
					cursor_q <= cursor_q + CW'(1);
					idx_q    <= idx_q + 2'd1;
					if (3'({1'b0, idx_q}) == nbytes - 3'd1) begin
						res_q   <= sgn_q ? sext(acc_byte, {nbytes, 3'b000}) : acc_byte;
						state_q <= S_DONE;
					end
				end
				S_BITS_STEP: begin
					if (rem_q == 6'd0) begin
						res_q   <= sgn_q ? sext(acc_q, nbits_q) : acc_q;
						state_q <= S_DONE;
					end else if (bitpos_q > 4'd7) begin
						bitpos_q <= 4'd0;
						if (left_x == '0) begin
							flag_q  <= 1'b1;
							held_q  <= '0;
							res_q   <= '0;
							state_q <= S_DONE;
						end else begin
							cursor_q <= cursor_q + CW'(1);
							state_q  <= S_BITS_WAIT;
						end
					end else begin
						acc_q    <= acc_bits;
						rem_q    <= rem_after;
						bitpos_q <= bitpos_q + take;
					end
				end
				S_BITS_WAIT: begin
					held_q <= ram_rdata;
					if (flag_q) begin
						// an earlier overrun stops the read after the fetch
						res_q   <= '0;
						state_q <= S_DONE;
					end else begin
						acc_q    <= acc_bits;
						rem_q    <= rem_after;
						bitpos_q <= take;
						state_q  <= S_BITS_STEP;
					end
				end
				S_DONE: begin
					if (!m_valid_q || m_tready) begin
						m_data_q  <= res_q;
						m_err_q   <= flag_q;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == S_EXEC)
		else $error("accepted operation did not start execution");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_DONE))
		else $error("result presented outside the completion state");

	a_flag_clear_restart: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(flag_q) |-> $past(state_q == S_EXEC && op_q == OP_RESTART))
		else $error("overrun flag cleared without a restart");

	a_cursor_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cursor_q) |-> $past(state_q != S_IDLE))
		else $error("cursor moved while idle");

endmodule
